FILE: hdl/thd_pkg.sv
// Shared types and constants for the toroidal hue diffusion block.
// Used by thd_core, thd_hue and the top level; no dependencies.
package thd_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int DIM_W      = 7;
  localparam int HUE_W      = 16;
  localparam int DRAW_W     = 17;
  localparam int DISP_W     = 9;

  localparam logic [DRAW_W-1:0] SPARK_LIMIT = 17'd99945;

  // v mod 720 via reciprocal: q = (v * RECIP) >> RECIP_SHIFT is q or q-1
  localparam int HUE_WRAP    = 720;
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP       = (1 << RECIP_SHIFT) / HUE_WRAP;
  localparam int Q_W         = 7;

  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_WRITE  = 2'd2;

  localparam logic [1:0] REG_GRID_WIDTH     = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_SOUND_REACTIVE = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] grid_width;
    logic [DIM_W-1:0] grid_height;
    logic             sound_reactive;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] pixel_x;
    logic [ROW_W-1:0] pixel_y;
    logic             frame_last;
    logic [HUE_W-1:0] value;
  } px_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] y,
                                                  input logic [COL_W-1:0] x);
    cell_addr = ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
  endfunction

endpackage

FILE: hdl/toroidal_hue_diffusion_effect.sv
// Toroidal hue diffusion block: configuration registers, grid sequencer and hue stage.
// Depends on thd_pkg, thd_core and thd_hue.
//
// An update beat reads in RD0, RD1 and RD2 on the two read ports of the grid
// memory, then writes the cell in WB0 on its single write port; WB1 and WB2
// follow when a spark zeroes three cells. A clear or write beat writes in WRC.
// The next beat is taken in the last cycle of the current one. Results leave
// through a two-stage hue pipeline (s1_r, then the output registers) behind the
// write-back, and a waiting result does not hold off input until that pipeline
// is full. After reset all 4096 cells are swept to zero while in_ready stays low;
// cfg writes are always taken and should be made only while the block is idle.
module toroidal_hue_diffusion_effect import thd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [COL_W-1:0]  in_cell_x,
  input  logic [ROW_W-1:0]  in_cell_y,
  input  logic [HUE_W-1:0]  in_write_value,
  input  logic [DRAW_W-1:0] in_spark_draw,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COL_W-1:0]  out_pixel_x,
  output logic [ROW_W-1:0]  out_pixel_y,
  output logic [DISP_W-1:0] out_hue_out,
  output logic              out_frame_last
);

  cfg_t cfg_r;
  logic px_valid, px_ready;
  px_t  px;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width     <= DIM_W'(MAX_WIDTH);
      cfg_r.grid_height    <= DIM_W'(MAX_HEIGHT);
      cfg_r.sound_reactive <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH:     cfg_r.grid_width     <= cfg_data;
        REG_GRID_HEIGHT:    cfg_r.grid_height    <= cfg_data;
        REG_SOUND_REACTIVE: cfg_r.sound_reactive <= cfg_data[0];
        default:            cfg_r <= cfg_r;
      endcase
    end
  end

  thd_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_write_value (in_write_value),
    .in_spark_draw  (in_spark_draw),
    .px_valid       (px_valid),
    .px_ready       (px_ready),
    .px             (px)
  );

  thd_hue u_hue (
    .clk            (clk),
    .rst_n          (rst_n),
    .px_valid       (px_valid),
    .px_ready       (px_ready),
    .px             (px),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_hue_out    (out_hue_out),
    .out_frame_last (out_frame_last)
  );

endmodule

FILE: hdl/thd_core.sv
// Grid store and update sequencer: clearing pass, read-modify-write of cells.
// Depends on thd_pkg.
module thd_core import thd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic [COL_W-1:0]    in_cell_x,
  input  logic [ROW_W-1:0]    in_cell_y,
  input  logic [HUE_W-1:0]    in_write_value,
  input  logic [DRAW_W-1:0]   in_spark_draw,
  output logic                px_valid,
  input  logic                px_ready,
  output px_t                 px
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_WRC   = 4'd2;
  localparam logic [3:0] ST_RD0   = 4'd3;
  localparam logic [3:0] ST_RD1   = 4'd4;
  localparam logic [3:0] ST_RD2   = 4'd5;
  localparam logic [3:0] ST_WB0   = 4'd6;
  localparam logic [3:0] ST_WB1   = 4'd7;
  localparam logic [3:0] ST_WB2   = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [COL_W-1:0]  scan_col_r, scan_col_nxt;
  logic [ROW_W-1:0]  scan_row_r, scan_row_nxt;

  // command beat
  logic [COL_W-1:0]  cmd_x_r;
  logic [ROW_W-1:0]  cmd_y_r;
  logic [HUE_W-1:0]  wval_r;
  logic [DRAW_W-1:0] draw_r;
  logic              is_wr_r;

  // cell being updated
  logic [COL_W-1:0]  x_r, right_r;
  logic [ROW_W-1:0]  y_r, above_r, below_r;
  logic              right_wrap_r, last_r;
  logic [HUE_W-1:0]  cur_r;
  logic [17:0]       part_r;
  logic [20:0]       base_r;

  // grid memory, one write and two read ports
  logic [HUE_W-1:0]  mem [DEPTH];
  logic [HUE_W-1:0]  rd_a_r, rd_b_r;
  logic              re, we;
  logic [ADDR_W-1:0] ra_a, ra_b, wa;
  logic [HUE_W-1:0]  wd;

  logic [DIM_W-1:0]  w, h;
  logic              restart;
  logic [COL_W-1:0]  x_c, left_c, right_c;
  logic [ROW_W-1:0]  y_c, above_c, below_c;
  logic              right_wrap_c, below_wrap_c, last_c;
  logic              accept, spark, cmd_in_grid;
  logic [17:0]       sum;
  logic [20:0]       upd_full;
  logic [HUE_W-1:0]  new_v;

  always_comb begin
    if (cfg.grid_width == '0) w = DIM_W'(1);
    else if (cfg.grid_width > DIM_W'(MAX_WIDTH)) w = DIM_W'(MAX_WIDTH);
    else w = cfg.grid_width;
    if (cfg.grid_height == '0) h = DIM_W'(1);
    else if (cfg.grid_height > DIM_W'(MAX_HEIGHT)) h = DIM_W'(MAX_HEIGHT);
    else h = cfg.grid_height;
  end

  // scan position and wrap-around neighbours, used in RD0
  always_comb begin
    restart      = (DIM_W'(scan_col_r) >= w) || (DIM_W'(scan_row_r) >= h);
    x_c          = restart ? '0 : scan_col_r;
    y_c          = restart ? '0 : scan_row_r;
    left_c       = (x_c == '0) ? COL_W'(w - DIM_W'(1)) : x_c - COL_W'(1);
    above_c      = (y_c == '0) ? ROW_W'(h - DIM_W'(1)) : y_c - ROW_W'(1);
    right_wrap_c = (DIM_W'(x_c) + DIM_W'(1)) >= w;
    below_wrap_c = (DIM_W'(y_c) + DIM_W'(1)) >= h;
    right_c      = right_wrap_c ? '0 : x_c + COL_W'(1);
    below_c      = below_wrap_c ? '0 : y_c + ROW_W'(1);
    last_c       = (DIM_W'(x_c) == w - DIM_W'(1)) && (DIM_W'(y_c) == h - DIM_W'(1));
  end

  always_comb begin
    sum      = part_r + 18'(rd_a_r);
    upd_full = base_r + 21'(sum);
    new_v    = upd_full[19:4];
    spark    = !cfg.sound_reactive && (draw_r > SPARK_LIMIT);
    cmd_in_grid = (DIM_W'(cmd_x_r) < w) && (DIM_W'(cmd_y_r) < h);
  end

  always_comb begin
    px_valid      = (state_r == ST_WB0);
    px.pixel_x    = x_r;
    px.pixel_y    = y_r;
    px.frame_last = last_r;
    if (spark) px.value = '0;
    else if (sum != {cur_r, 2'b00}) px.value = new_v;
    else px.value = cur_r;
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE) || (state_r == ST_WRC) || (state_r == ST_WB2) ||
               ((state_r == ST_WB0) && px_ready && !spark);
    accept   = in_valid && in_ready;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    scan_col_nxt = scan_col_r;
    scan_row_nxt = scan_row_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: state_nxt = ST_IDLE;
      ST_WRC:  state_nxt = ST_IDLE;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_WB0;
      ST_WB0: begin
        if (px_ready) begin
          state_nxt    = spark ? ST_WB1 : ST_IDLE;
          scan_col_nxt = right_r;
          scan_row_nxt = right_wrap_r ? below_r : y_r;
        end
      end
      ST_WB1:  state_nxt = ST_WB2;
      ST_WB2:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (accept) begin
      case (in_func)
        FUNC_UPDATE: state_nxt = ST_RD0;
        FUNC_CLEAR:  state_nxt = ST_WRC;
        FUNC_WRITE:  state_nxt = ST_WRC;
        default:     state_nxt = ST_IDLE;
      endcase
    end
  end

  // memory port selection
  always_comb begin
    re   = 1'b0;
    ra_a = cell_addr(y_c, x_c);
    ra_b = cell_addr(y_c, left_c);
    we   = 1'b0;
    wa   = cell_addr(y_r, x_r);
    wd   = '0;
    case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_cnt_r;
      end
      ST_WRC: begin
        we = cmd_in_grid;
        wa = cell_addr(cmd_y_r, cmd_x_r);
        wd = is_wr_r ? wval_r : '0;
      end
      ST_RD0: re = 1'b1;
      ST_RD1: begin
        re   = 1'b1;
        ra_a = cell_addr(y_r, right_r);
        ra_b = cell_addr(above_r, x_r);
      end
      ST_RD2: begin
        re   = 1'b1;
        ra_a = cell_addr(below_r, x_r);
        ra_b = cell_addr(below_r, x_r);
      end
      ST_WB0: begin
        we = px_ready;
        wd = px.value;
      end
      ST_WB1: begin
        we = 1'b1;
        wa = cell_addr(y_r, right_r);
      end
      ST_WB2: begin
        we = 1'b1;
        wa = cell_addr(below_r, x_r);
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) begin
      rd_a_r <= mem[ra_a];
      rd_b_r <= mem[ra_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_cnt_r  <= '0;
      scan_col_r <= '0;
      scan_row_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      scan_col_r <= scan_col_nxt;
      scan_row_r <= scan_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_x_r <= in_cell_x;
      cmd_y_r <= in_cell_y;
      wval_r  <= in_write_value;
      draw_r  <= in_spark_draw;
      is_wr_r <= (in_func == FUNC_WRITE);
    end
    if (state_r == ST_RD0) begin
      x_r          <= x_c;
      y_r          <= y_c;
      right_r      <= right_c;
      above_r      <= above_c;
      below_r      <= below_c;
      right_wrap_r <= right_wrap_c;
      last_r       <= last_c;
    end
    if (state_r == ST_RD1) begin
      cur_r  <= rd_a_r;
      part_r <= 18'(rd_b_r);
    end
    if (state_r == ST_RD2) begin
      part_r <= part_r + 18'(rd_a_r) + 18'(rd_b_r);
      base_r <= 21'(cur_r) * 21'd12 + 21'd39;
    end
  end

`ifndef SYNTH
  a_no_beat_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready) else $error("input taken during clearing pass");

  a_update_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == FUNC_UPDATE) |=> (state_r == ST_RD0))
    else $error("update beat did not start neighbour reads");

  a_reads_reach_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD2) |=> (state_r == ST_WB0)) else $error("read sequence broken");
`endif

endmodule

FILE: hdl/thd_hue.sv
// Display hue stage: value mod 720 halved, two registered stages with stall.
// Depends on thd_pkg.
module thd_hue import thd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              px_valid,
  output logic              px_ready,
  input  px_t               px,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COL_W-1:0]  out_pixel_x,
  output logic [ROW_W-1:0]  out_pixel_y,
  output logic [DISP_W-1:0] out_hue_out,
  output logic              out_frame_last
);

  logic              s1_valid_r, out_valid_r;
  px_t               s1_r;
  logic [Q_W-1:0]    q_r;
  logic [28:0]       prod;
  logic              s2_adv;
  logic [16:0]       diff;
  logic [10:0]       rem, rem_c;
  logic [DISP_W-1:0] hue_r;
  logic [COL_W-1:0]  x_out_r;
  logic [ROW_W-1:0]  y_out_r;
  logic              last_out_r;

  always_comb begin
    s2_adv   = !out_valid_r || out_ready;
    px_ready = !s1_valid_r || s2_adv;
    prod     = 29'(px.value) * 29'(RECIP);
    // estimate may be one short, so remainder is below twice the wrap
    diff     = 17'(s1_r.value) - 17'(q_r) * 17'(HUE_WRAP);
    rem      = diff[10:0];
    rem_c    = (rem >= 11'(HUE_WRAP)) ? rem - 11'(HUE_WRAP) : rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (px_ready) s1_valid_r <= px_valid;
      if (s2_adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (px_ready && px_valid) begin
      s1_r <= px;
      q_r  <= prod[28:RECIP_SHIFT];
    end
    if (s2_adv && s1_valid_r) begin
      hue_r      <= rem_c[9:1];
      x_out_r    <= s1_r.pixel_x;
      y_out_r    <= s1_r.pixel_y;
      last_out_r <= s1_r.frame_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue_out    = hue_r;
  assign out_pixel_x    = x_out_r;
  assign out_pixel_y    = y_out_r;
  assign out_frame_last = last_out_r;

`ifndef SYNTH
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (hue_r < 9'd360)) else $error("display hue out of range");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_adv) |=> s1_valid_r) else $error("stalled beat dropped");
`endif

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for toroidal_hue_diffusion_effect: queue-fed driver, monitor, scoreboard.
// Keeps its own copy of the hue grid and scan position; needs thd_pkg and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import thd_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int IDLE_PCT       = 11;
  localparam int NUM_PHASES     = 12;
  localparam int CALM_PHASE     = 7;
  localparam int HOLD_PHASE     = 9;

  // per phase: width and height register values, sound_reactive, random beat count
  localparam int PHASE_W [NUM_PHASES] = '{4, 1, 0, 1, 64, 127, 2, 5, 64, 3, 65, 6};
  localparam int PHASE_H [NUM_PHASES] = '{3, 1, 0, 64, 1, 127, 2, 7, 64, 2, 9, 4};
  localparam int PHASE_Q [NUM_PHASES] = '{0, 0, 1, 0, 1, 0, 0, 1, 0, 0, 0, 0};
  localparam int PHASE_N [NUM_PHASES] =
    '{200, 80, 60, 150, 150, 150, 150, 150, 100, 300, 150, 200};

  typedef struct {
    logic [1:0]        func;
    logic [COL_W-1:0]  cx;
    logic [ROW_W-1:0]  cy;
    logic [HUE_W-1:0]  wval;
    logic [DRAW_W-1:0] draw;
  } grid_cmd_t;

  typedef struct {
    logic [COL_W-1:0]  px;
    logic [ROW_W-1:0]  py;
    logic [DISP_W-1:0] hue;
    logic              last;
  } pixel_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [DIM_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_func = '0;
  logic [COL_W-1:0]  in_cell_x = '0;
  logic [ROW_W-1:0]  in_cell_y = '0;
  logic [HUE_W-1:0]  in_write_value = '0;
  logic [DRAW_W-1:0] in_spark_draw = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [COL_W-1:0]  out_pixel_x;
  logic [ROW_W-1:0]  out_pixel_y;
  logic [DISP_W-1:0] out_hue_out;
  logic              out_frame_last;

  toroidal_hue_diffusion_effect DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_write_value (in_write_value),
    .in_spark_draw  (in_spark_draw),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_hue_out    (out_hue_out),
    .out_frame_last (out_frame_last)
  );

  grid_cmd_t        cmd_queue[$];
  pixel_t           pixel_expected[$];
  grid_cmd_t        cmd_held;
  logic [HUE_W-1:0] hue_grid [DEPTH];
  int unsigned      scan_x, scan_y;
  logic [DIM_W-1:0] width_reg, height_reg;
  logic             quiet_reg;
  int               errors = 0;
  bit               calm = 1'b0;
  bit               hold_req = 1'b0;
  bit               hold_done = 1'b0;
  int               hold_left = 0;
  int unsigned      idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned used_dim(input logic [DIM_W-1:0] d, input int unsigned lim);
    if (d == 0) return 1;
    if (d > lim) return lim;
    return d;
  endfunction

  function automatic int unsigned at(input int unsigned x, input int unsigned y);
    return y * MAX_WIDTH + x;
  endfunction

  // Grid update for one accepted beat; an update beat queues its pixel.
  task automatic diffuse(input grid_cmd_t c);
    int unsigned w, h, x, y, lf, rt, up, dn, cur, sum;
    logic [HUE_W-1:0] v;
    pixel_t p;
    w = used_dim(width_reg, MAX_WIDTH);
    h = used_dim(height_reg, MAX_HEIGHT);
    if (c.func == FUNC_CLEAR || c.func == FUNC_WRITE) begin
      if (c.cx < w && c.cy < h)
        hue_grid[at(c.cx, c.cy)] = (c.func == FUNC_WRITE) ? c.wval : '0;
      return;
    end
    if (c.func != FUNC_UPDATE) return;
    // grid shrank under the scan position: start over at the origin
    if (scan_x >= w || scan_y >= h) begin
      scan_x = 0;
      scan_y = 0;
    end
    x = scan_x;
    y = scan_y;
    lf = (x == 0) ? w - 1 : x - 1;
    rt = (x + 1 >= w) ? 0 : x + 1;
    up = (y == 0) ? h - 1 : y - 1;
    dn = (y + 1 >= h) ? 0 : y + 1;
    cur = hue_grid[at(x, y)];
    sum = hue_grid[at(lf, y)];
    sum += hue_grid[at(rt, y)];
    sum += hue_grid[at(x, up)];
    sum += hue_grid[at(x, dn)];
    // ceil((3*cur + sum/4 + 6) / 4) in exact integer form
    if (sum != 4 * cur) hue_grid[at(x, y)] = HUE_W'((12 * cur + sum + 39) >> 4);
    if (!quiet_reg && c.draw > SPARK_LIMIT) begin
      hue_grid[at(x, y)]  = '0;
      hue_grid[at(rt, y)] = '0;
      hue_grid[at(x, dn)] = '0;
    end
    v = hue_grid[at(x, y)];
    p.px   = COL_W'(x);
    p.py   = ROW_W'(y);
    p.hue  = DISP_W'((v % HUE_WRAP) / 2);
    p.last = (x == w - 1) && (y == h - 1);
    pixel_expected.push_back(p);
    if (x + 1 >= w) begin
      scan_x = 0;
      scan_y = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      scan_x = x + 1;
    end
  endtask

  function automatic grid_cmd_t mk_cmd(input logic [1:0] f, input int unsigned x,
                                       input int unsigned y, input int unsigned val,
                                       input int unsigned draw);
    grid_cmd_t c;
    c.func = f;
    c.cx   = COL_W'(x);
    c.cy   = ROW_W'(y);
    c.wval = HUE_W'(val);
    c.draw = DRAW_W'(draw);
    return c;
  endfunction

  // Mostly updates and in-grid writes; some off-grid coordinates and spare codes.
  function automatic grid_cmd_t random_cmd(input int unsigned w, input int unsigned h);
    grid_cmd_t c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 62) c.func = FUNC_UPDATE;
    else if (pick < 86) c.func = FUNC_WRITE;
    else if (pick < 94) c.func = FUNC_CLEAR;
    else c.func = FUNC_SPARE;
    if ($urandom_range(0, 99) < 80) begin
      c.cx = COL_W'($urandom_range(0, w - 1));
      c.cy = ROW_W'($urandom_range(0, h - 1));
    end else begin
      c.cx = COL_W'($urandom);
      c.cy = ROW_W'($urandom);
    end
    c.wval = HUE_W'($urandom);
    if ($urandom_range(0, 99) < 85) c.draw = DRAW_W'($urandom_range(0, 99999));
    else c.draw = DRAW_W'($urandom_range(99900, (1 << DRAW_W) - 1));
    return c;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= DIM_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:     width_reg = DIM_W'(val);
      REG_GRID_HEIGHT:    height_reg = DIM_W'(val);
      REG_SOUND_REACTIVE: quiet_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input int unsigned w, input int unsigned h, input int unsigned q);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_SOUND_REACTIVE, q);
  endtask

  // sampled on the falling edge so queue and valid are settled
  task automatic drain();
    @(negedge clk);
    while (cmd_queue.size() != 0 || in_valid || pixel_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) diffuse(cmd_held);
      if (!in_valid || in_ready) begin
        if (cmd_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cmd_held = cmd_queue.pop_front();
          in_func        <= cmd_held.func;
          in_cell_x      <= cmd_held.cx;
          in_cell_y      <= cmd_held.cy;
          in_write_value <= cmd_held.wval;
          in_spark_draw  <= cmd_held.draw;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin : monitor
    pixel_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_expected.size() == 0) begin
          $error("unexpected beat: x %0d y %0d hue %0d", out_pixel_x, out_pixel_y, out_hue_out);
          errors++;
        end else begin
          e = pixel_expected.pop_front();
          if (out_pixel_x !== e.px) begin
            $error("pixel_x: expected %0d, got %0d", e.px, out_pixel_x);
            errors++;
          end
          if (out_pixel_y !== e.py) begin
            $error("pixel_y: expected %0d, got %0d", e.py, out_pixel_y);
            errors++;
          end
          if (out_hue_out !== e.hue) begin
            $error("hue_out: expected %0d, got %0d", e.hue, out_hue_out);
            errors++;
          end
          if (out_frame_last !== e.last) begin
            $error("frame_last: expected %0d, got %0d", e.last, out_frame_last);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        // long back-pressure while the driver keeps offering beats
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: cycles without any beat on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned w, h;
    for (int i = 0; i < DEPTH; i++) hue_grid[i] = '0;
    scan_x = 0;
    scan_y = 0;
    width_reg = 7'd64;
    height_reg = 7'd64;
    quiet_reg = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 4x3 grid, sparks on
    set_grid(4, 3, 0);
    @(negedge clk);
    cmd_queue.push_back(mk_cmd(FUNC_WRITE, 0, 0, 16'hFFFF, 0));
    cmd_queue.push_back(mk_cmd(FUNC_WRITE, 3, 2, 16'hFFFF, 0));
    cmd_queue.push_back(mk_cmd(FUNC_WRITE, 1, 1, 0, 0));
    cmd_queue.push_back(mk_cmd(FUNC_WRITE, 63, 63, 1234, 0));
    cmd_queue.push_back(mk_cmd(FUNC_WRITE, 4, 0, 16'h5555, 0));
    cmd_queue.push_back(mk_cmd(FUNC_WRITE, 0, 3, 16'hAAAA, 0));
    cmd_queue.push_back(mk_cmd(FUNC_SPARE, 63, 63, 16'hFFFF, 131071));
    cmd_queue.push_back(mk_cmd(FUNC_CLEAR, 3, 2, 0, 0));
    cmd_queue.push_back(mk_cmd(FUNC_WRITE, 2, 0, 719, 0));
    cmd_queue.push_back(mk_cmd(FUNC_WRITE, 1, 0, 720, 0));
    repeat (4) cmd_queue.push_back(mk_cmd(FUNC_UPDATE, 0, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(FUNC_UPDATE, 0, 0, 0, 99945));
    cmd_queue.push_back(mk_cmd(FUNC_UPDATE, 0, 0, 0, 99946));
    cmd_queue.push_back(mk_cmd(FUNC_UPDATE, 0, 0, 0, 131071));
    cmd_queue.push_back(mk_cmd(FUNC_UPDATE, 0, 0, 0, 99999));
    cmd_queue.push_back(mk_cmd(FUNC_CLEAR, 63, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(FUNC_CLEAR, 0, 0, 0, 0));
    repeat (6) cmd_queue.push_back(mk_cmd(FUNC_UPDATE, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_grid(PHASE_W[ph], PHASE_H[ph], PHASE_Q[ph]);
      @(negedge clk);
      calm = (ph == CALM_PHASE);
      w = used_dim(width_reg, MAX_WIDTH);
      h = used_dim(height_reg, MAX_HEIGHT);
      for (int k = 0; k < PHASE_N[ph]; k++) cmd_queue.push_back(random_cmd(w, h));
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      drain();
    end
    calm = 1'b0;

    if (errors == 0 && pixel_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
